// File: rtl/gbts_pkg.sv
`default_nettype none

package gbts_pkg;

   // Field widths of one request and one response beat.
   localparam int OpWidth     = 3;
   localparam int PosWidth    = 13;
   localparam int CharWidth   = 16;
   localparam int StatusWidth = 2;

   localparam int DefaultCapacity = 4096;

   // Operation codes.
   localparam logic [OpWidth-1:0] OP_INSERT    = 3'd0;
   localparam logic [OpWidth-1:0] OP_READ      = 3'd1;
   localparam logic [OpWidth-1:0] OP_OVERWRITE = 3'd2;
   localparam logic [OpWidth-1:0] OP_REMOVE    = 3'd3;
   localparam logic [OpWidth-1:0] OP_CLEAR     = 3'd4;

   // Status codes.
   localparam logic [StatusWidth-1:0] ST_OK    = 2'd0;
   localparam logic [StatusWidth-1:0] ST_RANGE = 2'd1;
   localparam logic [StatusWidth-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [OpWidth-1:0]   operation;
      logic [PosWidth-1:0]  position;
      logic [CharWidth-1:0] char_in;
   } req_type;

   typedef struct packed {
      logic [StatusWidth-1:0] status;
      logic [CharWidth-1:0]   char_out;
      logic [PosWidth-1:0]    text_length;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/gbts_char_ram.sv
`default_nettype none

module gbts_char_ram
   import gbts_pkg::*;
#(
   parameter int DEPTH = DefaultCapacity,
   parameter int AW    = $clog2(DefaultCapacity)
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [AW-1:0]        wr_addr,
   input  wire logic [CharWidth-1:0] wr_data,
   input  wire logic                 rd_en,
   input  wire logic [AW-1:0]        rd_addr,
   output logic      [CharWidth-1:0] rd_data
);

   logic [CharWidth-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Hold the last read word until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: rtl/gap_buffer_text_store.sv
`default_nettype none

// Channel   Dir  Handshake            Beat
// req_      in   req_valid/req_stall  req_data (operation, position, char_in)
// rsp_      out  rsp_valid/rsp_stall  rsp_data (status, char_out, text_length)
//
// One request at a time. After the accepting edge a request passes through:
//   clear, bad index, full insert, unknown code : DECODE, DONE
//   read : DECODE, READ, DONE; overwrite : DECODE, FINISH, DONE
//   insert or remove : DECODE, N move steps, MOVE_RD, FINISH, DONE
// N = cells the gap walks. Each move step is one character RAM read
// (MOVE_RD), then one write (MOVE_WR), per shifted cell; N can reach CAPACITY - 1.
// Reset clears the gap pointers and the response valid; the character RAM
// is not cleared (only cells holding text are ever read).
// A stalled response holds its beat; a new request is still accepted
// meanwhile, and its response waits in DONE until the output register frees.

module gap_buffer_text_store
   import gbts_pkg::*;
#(
   parameter int CAPACITY = DefaultCapacity
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int LW = $clog2(CAPACITY + 1);          // lengths 0..CAPACITY
   localparam int AW = $clog2(CAPACITY);              // cell addresses
   localparam int CW = (LW > PosWidth) ? LW : PosWidth; // compare width
   localparam logic [LW-1:0] CapLen = LW'(CAPACITY);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_DECODE  = 3'd1;
   localparam logic [2:0] S_MOVE_RD = 3'd2;
   localparam logic [2:0] S_MOVE_WR = 3'd3;
   localparam logic [2:0] S_FINISH  = 3'd4;
   localparam logic [2:0] S_READ    = 3'd5;
   localparam logic [2:0] S_DONE    = 3'd6;

   logic [2:0]             state_ff, state_in;
   logic [OpWidth-1:0]     op_ff, op_in;
   logic [CW-1:0]          pos_ff, pos_in;
   logic [CharWidth-1:0]   ch_ff, ch_in;
   logic [LW-1:0]          gb_ff, gb_in;    // gap begin
   logic [LW-1:0]          gs_ff, gs_in;    // gap size
   logic [AW-1:0]          src_ff, src_in;
   logic [AW-1:0]          dst_ff, dst_in;
   logic [LW-1:0]          cnt_ff, cnt_in;
   logic                   up_ff, up_in;
   logic [StatusWidth-1:0] status_ff, status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                 ram_wr_en;
   logic [AW-1:0]        ram_wr_addr;
   logic [CharWidth-1:0] ram_wr_data;
   logic                 ram_rd_en;
   logic [CharWidth-1:0] ram_rd_data;

   logic [LW-1:0] len_c;
   logic [CW-1:0] len_x, gb_x, gs_x, phys_c;

   // Current text length and the logical-to-cell mapping past the gap.
   assign len_c  = CapLen - gs_ff;
   assign len_x  = CW'(len_c);
   assign gb_x   = CW'(gb_ff);
   assign gs_x   = CW'(gs_ff);
   assign phys_c = (pos_ff < gb_x) ? pos_ff : pos_ff + gs_x;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      pos_in       = pos_ff;
      ch_in        = ch_ff;
      gb_in        = gb_ff;
      gs_in        = gs_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      cnt_in       = cnt_ff;
      up_in        = up_ff;
      status_in    = status_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = dst_ff;
      ram_wr_data  = ram_rd_data;
      ram_rd_en    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            // Take the request beat.
            if (req_valid) begin
               op_in    = req_data.operation;
               pos_in   = CW'(req_data.position);
               ch_in    = req_data.char_in;
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            status_in = ST_OK;
            state_in  = S_DONE;
            case (op_ff)
               OP_INSERT: begin
                  if (pos_ff > len_x) begin
                     status_in = ST_RANGE;
                  end else if (gs_ff == '0) begin
                     status_in = ST_FULL;
                  end else if (gb_x > pos_ff) begin
                     // Walk the gap left: shift cells up across the gap.
                     up_in    = 1'b0;
                     cnt_in   = LW'(gb_x - pos_ff);
                     src_in   = AW'(gb_x - CW'(1));
                     dst_in   = AW'(gb_x - CW'(1) + gs_x);
                     state_in = S_MOVE_RD;
                  end else begin
                     // Walk the gap right: pull cells down across the gap.
                     up_in    = 1'b1;
                     cnt_in   = LW'(pos_ff - gb_x);
                     src_in   = AW'(gb_x + gs_x);
                     dst_in   = AW'(gb_x);
                     state_in = S_MOVE_RD;
                  end
               end
               OP_READ, OP_OVERWRITE: begin
                  if (pos_ff >= len_x) begin
                     status_in = ST_RANGE;
                  end else begin
                     src_in   = AW'(phys_c);
                     dst_in   = AW'(phys_c);
                     state_in = (op_ff == OP_READ) ? S_READ : S_FINISH;
                  end
               end
               OP_REMOVE: begin
                  if (pos_ff >= len_x) begin
                     status_in = ST_RANGE;
                  end else if (pos_ff < gb_x) begin
                     // Close up the text before the gap.
                     up_in    = 1'b1;
                     cnt_in   = LW'(gb_x - CW'(1) - pos_ff);
                     src_in   = AW'(pos_ff + CW'(1));
                     dst_in   = AW'(pos_ff);
                     state_in = S_MOVE_RD;
                  end else begin
                     // Close up the text after the gap.
                     up_in    = 1'b0;
                     cnt_in   = LW'(pos_ff - gb_x);
                     src_in   = AW'(pos_ff + gs_x - CW'(1));
                     dst_in   = AW'(pos_ff + gs_x);
                     state_in = S_MOVE_RD;
                  end
               end
               OP_CLEAR: begin
                  gb_in = '0;
                  gs_in = CapLen;
               end
               default: begin
                  // Unused code: drop the item, report ok.
               end
            endcase
         end

         S_MOVE_RD: begin
            if (cnt_ff == '0) begin
               state_in = S_FINISH;
            end else begin
               ram_rd_en = 1'b1;
               state_in  = S_MOVE_WR;
            end
         end

         S_MOVE_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = dst_ff;
            ram_wr_data = ram_rd_data;
            cnt_in      = cnt_ff - LW'(1);
            if (up_ff) begin
               src_in = src_ff + AW'(1);
               dst_in = dst_ff + AW'(1);
            end else begin
               src_in = src_ff - AW'(1);
               dst_in = dst_ff - AW'(1);
            end
            state_in = S_MOVE_RD;
         end

         S_FINISH: begin
            state_in = S_DONE;
            case (op_ff)
               OP_INSERT: begin
                  // Gap now starts at the index: drop the character in.
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = AW'(pos_ff);
                  ram_wr_data = ch_ff;
                  gb_in       = LW'(pos_ff + CW'(1));
                  gs_in       = gs_ff - LW'(1);
               end
               OP_OVERWRITE: begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = dst_ff;
                  ram_wr_data = ch_ff;
               end
               OP_REMOVE: begin
                  if (up_ff) begin
                     gb_in = gb_ff - LW'(1);
                  end
                  gs_in = gs_ff + LW'(1);
               end
               default: begin
               end
            endcase
         end

         S_READ: begin
            ram_rd_en = 1'b1;
            state_in  = S_DONE;
         end

         S_DONE: begin
            // Load the response once the output register is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.status      = status_ff;
               rsp_in.char_out    = (op_ff == OP_READ && status_ff == ST_OK) ?
                                    ram_rd_data : '0;
               rsp_in.text_length = PosWidth'(len_c);
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         gb_ff        <= '0;
         gs_ff        <= CapLen;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gb_ff        <= gb_in;
         gs_ff        <= gs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      pos_ff    <= pos_in;
      ch_ff     <= ch_in;
      src_ff    <= src_in;
      dst_ff    <= dst_in;
      cnt_ff    <= cnt_in;
      up_ff     <= up_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   gbts_char_ram #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_char_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (src_ff),
      .rd_data (ram_rd_data)
   );

   // Gap never runs past the end of the store.
   assert property (@(posedge clock) disable iff (reset)
      ({1'b0, gb_ff} + {1'b0, gs_ff}) <= {1'b0, CapLen})
      else $error("gap extends past the store");

   // A move write always has a cell left to move.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MOVE_WR) |-> (cnt_ff != '0))
      else $error("move counter underflow");

   // Leaving DONE always presents a response beat.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && state_in == S_IDLE) |=> rsp_valid_ff)
      else $error("response lost on completion");

   // Gap pointers only move while a request is in progress.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && !$past(reset)) |-> ($stable(gb_ff) && $stable(gs_ff)))
      else $error("gap changed while idle");

endmodule

`default_nettype wire
